>>> hdl/dual_token_bucket_limiter_core_defines.svh
// assertion macros for the dual token bucket limiter checker
// needs clk and arst_n in the scope of each use
`ifndef DUAL_TOKEN_BUCKET_LIMITER_CORE_DEFINES_SVH
`define DUAL_TOKEN_BUCKET_LIMITER_CORE_DEFINES_SVH

// same-cycle implication
`define DTB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DTB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/dtb_pkg.sv
// shared types, constants and the divide-by-1000 digit step
// for the dual token bucket limiter; no dependencies
package dtb_pkg;

	localparam int PKT_W  = 32;
	localparam int BYTE_W = 40;
	localparam int TIME_W = 48;
	localparam int LEN_W  = 16;
	localparam int CNT_W  = 48;

	localparam int SCALE_LAT = 8;

	localparam logic [PKT_W-1:0]  PACKET_RATE_RST  = 32'd1000;
	localparam logic [BYTE_W-1:0] BYTE_RATE_RST    = 40'd1000000;
	localparam logic [PKT_W-1:0]  PACKET_BURST_RST = 32'd100;
	localparam logic [BYTE_W-1:0] BYTE_BURST_RST   = 40'd100000;

	// ceil(2^30 / 1000), exact for dividends below 1000 * 1024
	localparam logic [20:0] DIV_RECIP = 21'd1073742;
	// quotients at or above 2^40 always cap at the burst
	localparam logic [87:0] SAT_LIMIT = 88'd1000 << 40;

	typedef enum logic [1:0] {
		OP_PACKET = 2'd0,
		OP_TIME   = 2'd1,
		OP_RESET  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		CFG_PACKET_RATE  = 2'd0,
		CFG_BYTE_RATE    = 2'd1,
		CFG_PACKET_BURST = 2'd2,
		CFG_BYTE_BURST   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic             valid;
		opcode_t          op;
		logic [LEN_W-1:0] len;
		logic             refill;
	} item_t;

	typedef struct packed {
		logic [9:0] q;
		logic [9:0] r;
	} div_step_t;

	// one 10-bit quotient digit of a long division by 1000
	function automatic div_step_t div_step(input logic [9:0] rem_in, input logic [9:0] digit);
		logic [19:0] v;
		logic [40:0] prod;
		logic [19:0] r20;
		div_step_t   res;
		v     = {rem_in, digit};
		prod  = 41'(v) * 41'(DIV_RECIP);
		res.q = prod[39:30];
		// q * 1000 = q * 1024 - q * 16 - q * 8
		r20   = v - {res.q, 10'b0} + {6'b0, res.q, 4'b0} + {7'b0, res.q, 3'b0};
		res.r = r20[9:0];
		return res;
	endfunction

endpackage

>>> hdl/dtb_scale.sv
// pipelined floor(rate * elapsed / 1000) with saturation flag
// uses dtb_pkg; eight register stages, advanced by en
module dtb_scale (
	input  logic                       clk,
	input  logic                       en,
	input  logic [dtb_pkg::BYTE_W-1:0] rate,
	input  logic [dtb_pkg::TIME_W-1:0] elapsed,
	output logic [dtb_pkg::BYTE_W-1:0] add,
	output logic                       sat
);

	logic [63:0] pll_s2;
	logic [47:0] plh_s2;
	logic [39:0] phl_s2;
	logic [23:0] phh_s2;
	logic [48:0] mid_s3;
	logic [87:0] base_s3;
	logic [87:0] prod_s4;
	logic        sat_s5, sat_s6, sat_s7, sat_s8, sat_s9;
	logic [9:0]  rem_s5, rem_s6, rem_s7, rem_s8;
	logic [39:0] low_s5;
	logic [29:0] low_s6;
	logic [19:0] low_s7;
	logic [9:0]  low_s8;
	logic [9:0]  quo_s6;
	logic [19:0] quo_s7;
	logic [29:0] quo_s8;
	logic [39:0] quo_s9;

	dtb_pkg::div_step_t st0, st1, st2, st3;

	always_comb begin
		st0 = dtb_pkg::div_step(rem_s5, low_s5[39:30]);
		st1 = dtb_pkg::div_step(rem_s6, low_s6[29:20]);
		st2 = dtb_pkg::div_step(rem_s7, low_s7[19:10]);
		st3 = dtb_pkg::div_step(rem_s8, low_s8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// partial products
			pll_s2  <= 64'(rate[31:0]) * 64'(elapsed[31:0]);
			plh_s2  <= 48'(rate[31:0]) * 48'(elapsed[47:32]);
			phl_s2  <= 40'(rate[39:32]) * 40'(elapsed[31:0]);
			phh_s2  <= 24'(rate[39:32]) * 24'(elapsed[47:32]);
			// merge
			mid_s3  <= 49'(plh_s2) + 49'(phl_s2);
			base_s3 <= {phh_s2, pll_s2};
			prod_s4 <= base_s3 + {7'b0, mid_s3, 32'b0};
			// long division by 1000, top digit already below 1000 when not saturated
			sat_s5  <= prod_s4 >= dtb_pkg::SAT_LIMIT;
			rem_s5  <= prod_s4[49:40];
			low_s5  <= prod_s4[39:0];
			sat_s6  <= sat_s5;
			rem_s6  <= st0.r;
			quo_s6  <= st0.q;
			low_s6  <= low_s5[29:0];
			sat_s7  <= sat_s6;
			rem_s7  <= st1.r;
			quo_s7  <= {quo_s6, st1.q};
			low_s7  <= low_s6[19:0];
			sat_s8  <= sat_s7;
			rem_s8  <= st2.r;
			quo_s8  <= {quo_s7, st2.q};
			low_s8  <= low_s7[9:0];
			sat_s9  <= sat_s8;
			quo_s9  <= {quo_s8, st3.q};
		end
	end

	assign add = quo_s9;
	assign sat = sat_s9;

endmodule

>>> hdl/dual_token_bucket_limiter_core.sv
// top level of the dual token bucket limiter
// uses dtb_pkg and two dtb_scale refill pipelines
//
// item channel: opcode, packet_length, time_now; a beat moves when item_valid
// is high and item_stall low. result channel: accepted and the levels and drop
// counters after the item; a beat moves when result_valid is high and
// result_stall low. configuration: cfg_valid with cfg_index and cfg_data,
// always ready; the user must see that it is written between items only,
// the block does not enforce this. one item per cycle is taken for as long
// as results are taken. the refill product and divide by 1000 run through
// the eight-stage dtb_scale pipelines; the time latch sits at the input
// stage and the bucket and counter update in the final stage.
// while the result register holds a beat under result_stall the whole
// pipeline holds and item_stall is raised.
// reset empties the pipeline, restores the default rates and bursts, fills
// both buckets to the default bursts and clears the counters and the time.
module dual_token_bucket_limiter_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [1:0]                 opcode,
	input  logic [dtb_pkg::LEN_W-1:0]  packet_length,
	input  logic [dtb_pkg::TIME_W-1:0] time_now,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic                       accepted,
	output logic [dtb_pkg::PKT_W-1:0]  packet_level,
	output logic [dtb_pkg::BYTE_W-1:0] byte_level,
	output logic [dtb_pkg::CNT_W-1:0]  drop_count,
	output logic [dtb_pkg::CNT_W-1:0]  drop_bytes,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [dtb_pkg::BYTE_W-1:0] cfg_data
);

	logic [dtb_pkg::PKT_W-1:0]  packet_rate_q, packet_burst_q;
	logic [dtb_pkg::BYTE_W-1:0] byte_rate_q, byte_burst_q;

	logic [dtb_pkg::PKT_W-1:0]  pkt_tok_q, pkt_tok_nxt;
	logic [dtb_pkg::BYTE_W-1:0] byte_tok_q, byte_tok_nxt;
	logic [dtb_pkg::CNT_W-1:0]  drop_pkts_q, drop_pkts_nxt;
	logic [dtb_pkg::CNT_W-1:0]  drop_bytes_q, drop_bytes_nxt;
	logic [dtb_pkg::TIME_W-1:0] last_time_q;
	logic                       result_valid_q, accepted_q, admit_nxt;

	logic                       en, take;
	dtb_pkg::opcode_t           in_op;
	dtb_pkg::item_t             item_s1;
	dtb_pkg::item_t             item_pipe_q [0:dtb_pkg::SCALE_LAT-1];
	dtb_pkg::item_t             fin;
	logic [dtb_pkg::TIME_W-1:0] elapsed_s1;

	logic [dtb_pkg::BYTE_W-1:0] add_p, add_b;
	logic                       sat_p, sat_b;
	logic [dtb_pkg::BYTE_W:0]   pkt_sum, byte_sum;
	logic [dtb_pkg::CNT_W:0]    dbytes_sum;

	assign en         = !result_valid_q || !result_stall;
	assign item_stall = !en;
	assign take       = item_valid && en;
	assign in_op      = dtb_pkg::opcode_t'(opcode);
	assign cfg_ready  = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_rate_q  <= dtb_pkg::PACKET_RATE_RST;
			byte_rate_q    <= dtb_pkg::BYTE_RATE_RST;
			packet_burst_q <= dtb_pkg::PACKET_BURST_RST;
			byte_burst_q   <= dtb_pkg::BYTE_BURST_RST;
		end else if (cfg_valid) begin
			unique case (dtb_pkg::cfg_reg_t'(cfg_index))
				dtb_pkg::CFG_PACKET_RATE:  packet_rate_q  <= cfg_data[dtb_pkg::PKT_W-1:0];
				dtb_pkg::CFG_BYTE_RATE:    byte_rate_q    <= cfg_data;
				dtb_pkg::CFG_PACKET_BURST: packet_burst_q <= cfg_data[dtb_pkg::PKT_W-1:0];
				dtb_pkg::CFG_BYTE_BURST:   byte_burst_q   <= cfg_data;
			endcase
		end
	end

	// input stage: time latch and elapsed time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1     <= '0;
			last_time_q <= '0;
		end else if (en) begin
			item_s1.valid  <= take;
			item_s1.op     <= in_op;
			item_s1.len    <= packet_length;
			item_s1.refill <= take && in_op == dtb_pkg::OP_TIME && last_time_q != '0
				&& time_now > last_time_q;
			if (take && in_op == dtb_pkg::OP_TIME
				&& (last_time_q == '0 || time_now > last_time_q)) begin
				last_time_q <= time_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			elapsed_s1 <= time_now - last_time_q;
		end
	end

	// item control alongside the refill pipelines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dtb_pkg::SCALE_LAT; i++) begin
				item_pipe_q[i] <= '0;
			end
		end else if (en) begin
			item_pipe_q[0] <= item_s1;
			for (int i = 1; i < dtb_pkg::SCALE_LAT; i++) begin
				item_pipe_q[i] <= item_pipe_q[i-1];
			end
		end
	end

	dtb_scale u_scale_pkt (
		.clk     (clk),
		.en      (en),
		.rate    ({{(dtb_pkg::BYTE_W-dtb_pkg::PKT_W){1'b0}}, packet_rate_q}),
		.elapsed (elapsed_s1),
		.add     (add_p),
		.sat     (sat_p)
	);

	dtb_scale u_scale_byte (
		.clk     (clk),
		.en      (en),
		.rate    (byte_rate_q),
		.elapsed (elapsed_s1),
		.add     (add_b),
		.sat     (sat_b)
	);

	assign fin = item_pipe_q[dtb_pkg::SCALE_LAT-1];

	// bucket and counter update
	always_comb begin
		pkt_sum        = (dtb_pkg::BYTE_W+1)'(pkt_tok_q) + (dtb_pkg::BYTE_W+1)'(add_p);
		byte_sum       = (dtb_pkg::BYTE_W+1)'(byte_tok_q) + (dtb_pkg::BYTE_W+1)'(add_b);
		dbytes_sum     = (dtb_pkg::CNT_W+1)'(drop_bytes_q) + (dtb_pkg::CNT_W+1)'(fin.len);
		pkt_tok_nxt    = pkt_tok_q;
		byte_tok_nxt   = byte_tok_q;
		drop_pkts_nxt  = drop_pkts_q;
		drop_bytes_nxt = drop_bytes_q;
		admit_nxt      = 1'b0;
		unique case (fin.op)
			dtb_pkg::OP_PACKET: begin
				if (pkt_tok_q != '0 && byte_tok_q >= dtb_pkg::BYTE_W'(fin.len)) begin
					admit_nxt    = 1'b1;
					pkt_tok_nxt  = pkt_tok_q - 1'b1;
					byte_tok_nxt = byte_tok_q - dtb_pkg::BYTE_W'(fin.len);
				end else begin
					if (drop_pkts_q != '1) begin
						drop_pkts_nxt = drop_pkts_q + 1'b1;
					end
					drop_bytes_nxt = dbytes_sum[dtb_pkg::CNT_W] ? '1
						: dbytes_sum[dtb_pkg::CNT_W-1:0];
				end
			end
			dtb_pkg::OP_TIME: begin
				if (fin.refill) begin
					pkt_tok_nxt = (sat_p || pkt_sum >= (dtb_pkg::BYTE_W+1)'(packet_burst_q))
						? packet_burst_q : pkt_sum[dtb_pkg::PKT_W-1:0];
					byte_tok_nxt = (sat_b || byte_sum >= (dtb_pkg::BYTE_W+1)'(byte_burst_q))
						? byte_burst_q : byte_sum[dtb_pkg::BYTE_W-1:0];
				end
			end
			dtb_pkg::OP_RESET: begin
				pkt_tok_nxt    = packet_burst_q;
				byte_tok_nxt   = byte_burst_q;
				drop_pkts_nxt  = '0;
				drop_bytes_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			accepted_q     <= 1'b0;
			pkt_tok_q      <= dtb_pkg::PACKET_BURST_RST;
			byte_tok_q     <= dtb_pkg::BYTE_BURST_RST;
			drop_pkts_q    <= '0;
			drop_bytes_q   <= '0;
		end else if (en) begin
			result_valid_q <= fin.valid;
			if (fin.valid) begin
				accepted_q   <= admit_nxt;
				pkt_tok_q    <= pkt_tok_nxt;
				byte_tok_q   <= byte_tok_nxt;
				drop_pkts_q  <= drop_pkts_nxt;
				drop_bytes_q <= drop_bytes_nxt;
			end
		end
	end

	// state only moves with a result beat, so it doubles as the result payload
	assign result_valid = result_valid_q;
	assign accepted     = accepted_q;
	assign packet_level = pkt_tok_q;
	assign byte_level   = byte_tok_q;
	assign drop_count   = drop_pkts_q;
	assign drop_bytes   = drop_bytes_q;

endmodule

>>> hdl/dtb_checker.sv
// port-level checks for the dual token bucket limiter
// uses dual_token_bucket_limiter_core_defines.svh; bound to the top level
`include "dual_token_bucket_limiter_core_defines.svh"

module dtb_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      item_stall,
	input logic                      result_valid,
	input logic                      result_stall,
	input logic                      accepted,
	input logic [dtb_pkg::PKT_W-1:0] packet_level
);

	// the input side only holds back behind a stalled result beat
	`DTB_ASSERT_NOW(a_stall_cause, item_stall, result_valid && result_stall, "stall without cause")

	// a stalled result beat stays offered
	`DTB_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid, "result dropped")

	// an admitted packet used a token, so the level cannot be full scale
	`DTB_ASSERT_NOW(a_admit_level, result_valid && accepted, packet_level != '1, "admit at full")

	// an empty result slot never holds back the input
	`DTB_ASSERT_NOW(a_free_flow, !result_valid, !item_stall, "stall with empty result slot")

endmodule

bind dual_token_bucket_limiter_core dtb_checker u_dtb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.accepted     (accepted),
	.packet_level (packet_level)
);
